[rtl/etc_pkg.sv]
// ----------------------------------------------------------------------------
// etc_pkg
// Shared types and constants of the escape-time pixel colour pipeline.
// ----------------------------------------------------------------------------
package etc_pkg;

   // iteration limit and widths
   localparam int ITERS   = 16;
   localparam int IDX_W   = 5;
   localparam int ZW      = 36;   // z while still bounded
   localparam int CW      = 62;   // seed point c
   localparam int DW      = 32;   // divisor / remainder
   localparam int DIV_N   = 33;   // bits of the dividend 2^32

   // escape limit 2.0 in Q.32
   localparam logic signed [36:0] ESC_HI = 37'sh0_2_0000_0000;
   localparam logic signed [36:0] ESC_LO = -37'sh0_2_0000_0000;

   // register map
   typedef enum logic [1:0] {
      CSR_SEED = 2'd0,
      CSR_XOFF = 2'd1,
      CSR_YOFF = 2'd2
   } etc_csr_type;

   // iteration token
   typedef struct packed {
      logic                    vld;
      logic                    esc;
      logic [IDX_W-1:0]        idx;
      logic signed [ZW-1:0]    z;
      logic signed [CW-1:0]    c;
   } etc_tok_type;

   // remainder token
   typedef struct packed {
      logic             vld;
      logic             esc;
      logic [IDX_W-1:0] idx;
      logic [DW-1:0]    dvs;
      logic [DW-1:0]    rem;
   } etc_div_type;

endpackage

[rtl/etc_seed.sv]
// ----------------------------------------------------------------------------
// etc_seed
// Forms c = (x + xo) * (y + yo) + seed over five stages, flags escape in
// round zero.
// ----------------------------------------------------------------------------
module etc_seed (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       en,
   input  logic                       in_vld,
   input  logic signed [46:0]         coord_x,
   input  logic signed [46:0]         coord_y,
   input  logic signed [48:0]         seed,
   input  logic signed [12:0]         xoff,
   input  logic signed [12:0]         yoff,
   output etc_pkg::etc_tok_type       tok
);

   logic signed [13:0] xo;
   logic signed [13:0] yo;
   logic signed [47:0] a;
   logic signed [47:0] b;
   logic [47:0]        am;
   logic [47:0]        bm;

   logic        v1_ff, v2_ff, v3_ff, v4_ff;
   logic [46:0] am_ff, bm_ff;
   logic        neg1_ff, neg2_ff, neg3_ff;
   logic [63:0] pll_ff;
   logic [46:0] plh_ff, phl_ff;
   logic [29:0] phh_ff;
   logic [93:0] prod_in;
   logic [61:0] r_ff;
   logic signed [61:0] c_in, c_ff;
   etc_pkg::etc_tok_type tok_in, tok_ff;

   // offsets floored to a multiple of 8, less 128
   assign xo = $signed({xoff[12], xoff[12:3], 3'b000}) - 14'sd128;
   assign yo = $signed({yoff[12], yoff[12:3], 3'b000}) - 14'sd128;
   assign a  = {coord_x[46], coord_x} + {{2{xo[13]}}, xo, 32'b0};
   assign b  = {coord_y[46], coord_y} + {{2{yo[13]}}, yo, 32'b0};
   assign am = a[47] ? -a : a;
   assign bm = b[47] ? -b : b;

   // stage 1: magnitudes
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_vld;
      end
      if (en) begin
         am_ff   <= am[46:0];
         bm_ff   <= bm[46:0];
         neg1_ff <= a[47] ^ b[47];
      end
   end

   // stage 2: partial products
   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en) begin
         v2_ff <= v1_ff;
      end
      if (en) begin
         pll_ff  <= am_ff[31:0] * bm_ff[31:0];
         plh_ff  <= am_ff[31:0] * bm_ff[46:32];
         phl_ff  <= am_ff[46:32] * bm_ff[31:0];
         phh_ff  <= am_ff[46:32] * bm_ff[46:32];
         neg2_ff <= neg1_ff;
      end
   end

   // stage 3: sum, truncate to Q.32
   assign prod_in = {30'b0, pll_ff} + {15'b0, plh_ff, 32'b0} + {15'b0, phl_ff, 32'b0}
                  + {phh_ff, 64'b0};

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (en) begin
         v3_ff <= v2_ff;
      end
      if (en) begin
         r_ff    <= prod_in[93:32];
         neg3_ff <= neg2_ff;
      end
   end

   // stage 4: sign and seed
   assign c_in = (neg3_ff ? -$signed(r_ff) : $signed(r_ff)) + {{13{seed[48]}}, seed};

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (en) begin
         v4_ff <= v3_ff;
      end
      if (en) begin
         c_ff <= c_in;
      end
   end

   // stage 5: round zero, z = c
   always_comb begin
      tok_in.vld = v4_ff;
      tok_in.c   = c_ff;
      tok_in.z   = c_ff[etc_pkg::ZW-1:0];
      tok_in.idx = '0;
      tok_in.esc = (c_ff >= 62'sh2_0000_0000) || (c_ff <= -62'sh2_0000_0000);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.vld <= 1'b0;
      end else if (en) begin
         tok_ff.vld <= tok_in.vld;
      end
      if (en) begin
         tok_ff.esc <= tok_in.esc;
         tok_ff.idx <= tok_in.idx;
         tok_ff.z   <= tok_in.z;
         tok_ff.c   <= tok_in.c;
      end
   end

   assign tok = tok_ff;

endmodule

[rtl/etc_iter.sv]
// ----------------------------------------------------------------------------
// etc_iter
// One round of z = z*z + c: square stage, then add and escape test.
// ----------------------------------------------------------------------------
module etc_iter (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              en,
   input  logic [etc_pkg::IDX_W-1:0]         round,
   input  etc_pkg::etc_tok_type              tok_i,
   output etc_pkg::etc_tok_type              tok_o
);

   logic signed [etc_pkg::ZW-1:0] zm;
   logic [65:0]                   sq_ff;
   etc_pkg::etc_tok_type          a_ff, tok_in, tok_ff;
   logic signed [36:0]            znew;
   logic                          esc_now;

   // z is below 2 here unless already escaped
   assign zm = tok_i.z[etc_pkg::ZW-1] ? -tok_i.z : tok_i.z;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ff.vld <= 1'b0;
      end else if (en) begin
         a_ff.vld <= tok_i.vld;
      end
      if (en) begin
         a_ff.esc <= tok_i.esc;
         a_ff.idx <= tok_i.idx;
         a_ff.z   <= tok_i.z;
         a_ff.c   <= tok_i.c;
         sq_ff    <= zm[32:0] * zm[32:0];
      end
   end

   // add c, test |z| >= 2
   assign znew    = $signed({3'b000, sq_ff[65:32]})
                  + {a_ff.c[etc_pkg::ZW-1], a_ff.c[etc_pkg::ZW-1:0]};
   assign esc_now = (znew >= etc_pkg::ESC_HI) || (znew <= etc_pkg::ESC_LO);

   always_comb begin
      tok_in = a_ff;
      if (!a_ff.esc) begin
         tok_in.z = znew[etc_pkg::ZW-1:0];
         if (esc_now) begin
            tok_in.esc = 1'b1;
            tok_in.idx = round;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.vld <= 1'b0;
      end else if (en) begin
         tok_ff.vld <= tok_in.vld;
      end
      if (en) begin
         tok_ff.esc <= tok_in.esc;
         tok_ff.idx <= tok_in.idx;
         tok_ff.z   <= tok_in.z;
         tok_ff.c   <= tok_in.c;
      end
   end

   assign tok_o = tok_ff;

endmodule

[rtl/etc_remstep.sv]
// ----------------------------------------------------------------------------
// etc_remstep
// One restoring step of the remainder 2^32 mod d.
// ----------------------------------------------------------------------------
module etc_remstep (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 dbit,
   input  etc_pkg::etc_div_type dv_i,
   output etc_pkg::etc_div_type dv_o
);

   logic [etc_pkg::DW:0] t;
   logic [etc_pkg::DW:0] t_sub;
   etc_pkg::etc_div_type dv_ff;

   assign t     = {dv_i.rem, dbit};
   assign t_sub = (t >= {1'b0, dv_i.dvs}) ? t - {1'b0, dv_i.dvs} : t;

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_ff.vld <= 1'b0;
      end else if (en) begin
         dv_ff.vld <= dv_i.vld;
      end
      if (en) begin
         dv_ff.esc <= dv_i.esc;
         dv_ff.idx <= dv_i.idx;
         dv_ff.dvs <= dv_i.dvs;
         dv_ff.rem <= t_sub[etc_pkg::DW-1:0];
      end
   end

   assign dv_o = dv_ff;

endmodule

[rtl/etc_color.sv]
// ----------------------------------------------------------------------------
// etc_color
// Colour from |z*c|: split product, divisor, remainder chain, saturating
// channel add, output register.
// ----------------------------------------------------------------------------
module etc_color (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  etc_pkg::etc_tok_type tok_i,
   output logic                 out_vld,
   output logic [7:0]           red,
   output logic [7:0]           green,
   output logic [7:0]           blue,
   output logic                 escaped,
   output logic [4:0]           iter_count
);

   logic signed [etc_pkg::CW-1:0] cm_s, zm_s;
   logic [etc_pkg::CW-1:0]        cm, zm;
   logic                          v1_ff;
   logic                          esc1_ff;
   logic [etc_pkg::IDX_W-1:0]     idx1_ff;
   logic [63:0]                   p00_ff;
   logic [61:0]                   p01_ff, p10_ff;
   logic [59:0]                   p11_ff;
   logic [95:0]                   sum;
   etc_pkg::etc_div_type          dv0_in, dv0_ff;
   etc_pkg::etc_div_type          chain [etc_pkg::DIV_N+1];
   etc_pkg::etc_div_type          last;
   logic [etc_pkg::DW-1:0]        val;
   logic [8:0]                    r_s, g_s, b_s;
   logic                          vo_ff, esc_ff;
   logic [7:0]                    r_ff, g_ff, b_ff;
   logic [4:0]                    it_ff;

   // magnitudes; z is c when it escaped in round zero
   assign cm_s = tok_i.c[etc_pkg::CW-1] ? -tok_i.c : tok_i.c;
   assign zm_s = (tok_i.esc && tok_i.idx == '0) ? cm_s
               : (tok_i.z[etc_pkg::ZW-1] ? -{{(etc_pkg::CW-etc_pkg::ZW){tok_i.z[etc_pkg::ZW-1]}},
                                             tok_i.z}
                                         : {{(etc_pkg::CW-etc_pkg::ZW){1'b0}}, tok_i.z});
   assign cm = cm_s;
   assign zm = zm_s;

   // stage 1: partial products
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= tok_i.vld;
      end
      if (en) begin
         p00_ff  <= zm[31:0] * cm[31:0];
         p01_ff  <= zm[31:0] * cm[61:32];
         p10_ff  <= zm[61:32] * cm[31:0];
         p11_ff  <= zm[61:32] * cm[61:32];
         esc1_ff <= tok_i.esc;
         idx1_ff <= tok_i.esc ? tok_i.idx : etc_pkg::IDX_W'(etc_pkg::ITERS);
      end
   end

   // stage 2: integer part of K, plus one, mod 2^32
   assign sum = {32'b0, p00_ff} + {2'b0, p01_ff, 32'b0} + {2'b0, p10_ff, 32'b0}
              + {p11_ff[31:0], 64'b0};

   always_comb begin
      dv0_in.vld = v1_ff;
      dv0_in.esc = esc1_ff;
      dv0_in.idx = idx1_ff;
      dv0_in.dvs = sum[95:64] + 32'd1;
      dv0_in.rem = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv0_ff.vld <= 1'b0;
      end else if (en) begin
         dv0_ff.vld <= dv0_in.vld;
      end
      if (en) begin
         dv0_ff.esc <= dv0_in.esc;
         dv0_ff.idx <= dv0_in.idx;
         dv0_ff.dvs <= dv0_in.dvs;
         dv0_ff.rem <= dv0_in.rem;
      end
   end

   // remainder chain, one dividend bit a stage, MSB of 2^32 first
   assign chain[0] = dv0_ff;

   for (genvar i = 0; i < etc_pkg::DIV_N; i++) begin : g_rem
      etc_remstep u_step (
         .clock (clock),
         .reset (reset),
         .en    (en),
         .dbit  ((i == 0) ? 1'b1 : 1'b0),
         .dv_i  (chain[i]),
         .dv_o  (chain[i+1])
      );
   end

   assign last = chain[etc_pkg::DIV_N];

   // colour channels, saturated
   assign val = (last.dvs == '0) ? '0 : last.rem;
   assign r_s = {1'b0, val[23:16]} + {4'b0, last.idx};
   assign g_s = {1'b0, val[15:8]}  + {4'b0, last.idx};
   assign b_s = {1'b0, val[7:0]}   + {4'b0, last.idx};

   always_ff @(posedge clock) begin
      if (reset) begin
         vo_ff <= 1'b0;
      end else if (en) begin
         vo_ff <= last.vld;
      end
      if (en) begin
         esc_ff <= last.esc;
         it_ff  <= last.idx;
         r_ff   <= !last.esc ? 8'd0 : (r_s[8] ? 8'hff : r_s[7:0]);
         g_ff   <= !last.esc ? 8'd0 : (g_s[8] ? 8'hff : g_s[7:0]);
         b_ff   <= !last.esc ? 8'd0 : (b_s[8] ? 8'hff : b_s[7:0]);
      end
   end

   assign out_vld    = vo_ff;
   assign red        = r_ff;
   assign green      = g_ff;
   assign blue       = b_ff;
   assign escaped    = esc_ff;
   assign iter_count = it_ff;

endmodule

[rtl/escape_time_pixel_color_unit.sv]
// ----------------------------------------------------------------------------
// escape_time_pixel_color_unit
// Escape-time colour of one sample point, fully pipelined.
// ----------------------------------------------------------------------------
// One coordinate pair enters per clock while the pipeline advances: 5 stages form
// the seed point c, 30 stages run fifteen squaring rounds (two stages each, the
// first round is z = c), 2 stages form the divisor from |z*c|, 33 stages take
// 2^32 mod d one bit at a time, and one stage is the output register. The whole
// pipeline holds while a response waits unaccepted. The user must write registers
// through csr_* only while no transaction is in flight; the block does not enforce this.
module escape_time_pixel_color_unit (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [95:0]  req_tdata,   // coord_x[46:0], coord_y[93:47], zero pad
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [31:0]  rsp_tdata,   // red, green, blue, escaped, iter_count[29:25], pad
   input  logic         csr_we,
   input  logic [1:0]   csr_idx,
   input  logic [48:0]  csr_wdata
);

   logic signed [48:0] seed_ff;
   logic signed [12:0] xoff_ff, yoff_ff;
   logic               en;
   etc_pkg::etc_tok_type tok [etc_pkg::ITERS];
   logic [7:0]         red, green, blue;
   logic               escaped;
   logic [4:0]         iter_count;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= '0;
         xoff_ff <= '0;
         yoff_ff <= '0;
      end else if (csr_we) begin
         case (etc_pkg::etc_csr_type'(csr_idx))
            etc_pkg::CSR_SEED: seed_ff <= csr_wdata;
            etc_pkg::CSR_XOFF: xoff_ff <= csr_wdata[12:0];
            etc_pkg::CSR_YOFF: yoff_ff <= csr_wdata[12:0];
            default: ;
         endcase
      end
   end

   // global advance
   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;

   etc_seed u_seed (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .in_vld  (req_tvalid),
      .coord_x (req_tdata[46:0]),
      .coord_y (req_tdata[93:47]),
      .seed    (seed_ff),
      .xoff    (xoff_ff),
      .yoff    (yoff_ff),
      .tok     (tok[0])
   );

   for (genvar k = 1; k < etc_pkg::ITERS; k++) begin : g_iter
      etc_iter u_iter (
         .clock (clock),
         .reset (reset),
         .en    (en),
         .round (etc_pkg::IDX_W'(k)),
         .tok_i (tok[k-1]),
         .tok_o (tok[k])
      );
   end

   etc_color u_color (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .tok_i      (tok[etc_pkg::ITERS-1]),
      .out_vld    (rsp_tvalid),
      .red        (red),
      .green      (green),
      .blue       (blue),
      .escaped    (escaped),
      .iter_count (iter_count)
   );

   assign rsp_tdata = {2'b00, iter_count, escaped, blue, green, red};

   // checks
   a_black: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !escaped |-> red == 8'd0 && green == 8'd0 && blue == 8'd0)
      else $error("non-escaped point not black");

   a_full: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !escaped |-> iter_count == 5'(etc_pkg::ITERS))
      else $error("non-escaped point with short count");

   a_short: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && escaped |-> iter_count < 5'(etc_pkg::ITERS))
      else $error("escaped point with full count");

endmodule

[tb/sv/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the escape-time pixel colour unit. A directed table
// (register extremes, exact escape at 2.0, zero divisor, bounded orbits) runs
// first. Random coordinates follow, most of them placed near the origin of the
// offset grid so that orbits run deep. Each response transaction is compared
// field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb;

   localparam longint COORD_LIM  = 64'sd54975581388800;
   localparam longint ONE_Q      = 64'sd1 <<< 32;
   localparam longint SEED_MAX   = 64'sd281474976710655;
   localparam longint SEED_MIN   = -64'sd281474976710656;
   localparam logic [1:0] CSR_SPARE = 2'd3;   // no register behind it
   localparam int PHASES      = 6;
   localparam int PHASE_ITEMS = 173;
   localparam int DRAIN_WAIT  = 80;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       escaped;
      logic [4:0] iters;
   } pixel_type;

   typedef struct {
      bit        load;      // program the registers before this row
      longint    seed;
      int        xo;
      int        yo;
      longint    x;
      longint    y;
      bit        typed;     // expected pixel given below
      pixel_type px;
   } step_type;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [95:0]  req_tdata;    // coord_x[46:0], coord_y[93:47], zero pad
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [31:0]  rsp_tdata;    // red, green, blue, escaped, iter_count[29:25], pad
   logic         csr_we;
   logic [1:0]   csr_idx;
   logic [48:0]  csr_wdata;

   // register copies
   logic signed [48:0] seed_reg;
   logic signed [12:0] xoff_reg;
   logic signed [12:0] yoff_reg;

   pixel_type pixels_due[$];
   int     mismatch_count = 0;
   int     send_idle_pct;
   int     recv_idle_pct;
   int     stall_left = 0;

   escape_time_pixel_color_unit i_dut (.*);

   always begin
      clock = 1'b1; #1;
      clock = 1'b0; #1;
   end

   initial begin
      #4000000;
      $display("tb: failure");
      $finish;
   end

   // ---------------------------------------------------------------- predictor
   function automatic logic [63:0] magnitude(longint v);
      return v < 0 ? 64'(-v) : 64'(v);
   endfunction

   // Q.32 product, truncated toward zero, saturated
   function automatic longint qmul(longint a, longint b);
      logic [127:0] p;
      logic [63:0]  r;
      p = {64'd0, magnitude(a)} * {64'd0, magnitude(b)};
      r = p[95:32];
      if (p[127:96] != 0 || r > 64'h3FFF_FFFF_FFFF_FFFF) r = 64'h3FFF_FFFF_FFFF_FFFF;
      return ((a < 0) != (b < 0)) ? -longint'(r) : longint'(r);
   endfunction

   // offset floored to a multiple of 8, less 128, in Q.32
   function automatic longint grid_origin(logic signed [12:0] raw);
      longint v;
      v = raw;
      return (v - (v & 7) - 128) <<< 32;
   endfunction

   function automatic pixel_type predict_pixel(longint cx, longint cy);
      longint       c, z;
      int           n;
      logic [127:0] p;
      logic [31:0]  d;
      logic [63:0]  val;
      logic [8:0]   ch [3];
      pixel_type    px;
      c = qmul(cx + grid_origin(xoff_reg), cy + grid_origin(yoff_reg)) + longint'(seed_reg);
      z = 0;
      for (n = 0; n < etc_pkg::ITERS; n++) begin
         z = qmul(z, z) + c;
         if (magnitude(z) >= 64'h2_0000_0000) break;
      end
      px = '0;
      px.iters = n[4:0];
      if (n < etc_pkg::ITERS) begin
         p = {64'd0, magnitude(z)} * {64'd0, magnitude(c)};
         d = p[95:64] + 32'd1;
         val = (d == 0) ? 64'd0 : 64'h1_0000_0000 % {32'd0, d};
         for (int k = 0; k < 3; k++)
            ch[k] = 9'(val[8*(2-k) +: 8]) + 9'(n);
         px.red   = ch[0][8] ? 8'hFF : ch[0][7:0];
         px.green = ch[1][8] ? 8'hFF : ch[1][7:0];
         px.blue  = ch[2][8] ? 8'hFF : ch[2][7:0];
         px.escaped = 1'b1;
      end
      return px;
   endfunction

   // ---------------------------------------------------------------- stimulus
   function automatic longint wide_coord();
      logic [63:0] u;
      u = {$urandom, $urandom};
      return longint'(u % 64'(2 * COORD_LIM + 1)) - COORD_LIM;
   endfunction

   // within [-3, 3) of the point where the offset cancels
   function automatic longint near_coord(logic signed [12:0] raw);
      return -grid_origin(raw) + longint'({32'($urandom_range(0, 5)), 32'($urandom)})
             - 3 * ONE_Q;
   endfunction

   // called just after a rising edge; returns just after the accepting edge
   task automatic offer(longint x, longint y, bit typed, pixel_type px);
      while (send_idle_pct != 0 && $urandom_range(1, 100) <= send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b0, y[46:0], x[46:0]};
      do @(posedge clock); while (!req_tready);
      pixels_due.push_back(typed ? px : predict_pixel(x, y));
   endtask

   task automatic program_regs(longint seed, int xo, int yo, bit spare);
      req_tvalid <= 1'b0;
      while (pixels_due.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      csr_we <= 1'b1; csr_idx <= etc_pkg::CSR_SEED; csr_wdata <= seed[48:0];
      @(posedge clock);
      seed_reg = seed[48:0];
      csr_idx <= etc_pkg::CSR_XOFF; csr_wdata <= 49'(xo[12:0]);
      @(posedge clock);
      xoff_reg = xo[12:0];
      csr_idx <= etc_pkg::CSR_YOFF; csr_wdata <= 49'(yo[12:0]);
      @(posedge clock);
      yoff_reg = yo[12:0];
      if (spare) begin
         csr_idx <= CSR_SPARE; csr_wdata <= 49'({$urandom, $urandom});
         @(posedge clock);
      end
      csr_we <= 1'b0;
   endtask

   // ---------------------------------------------------------------- receiver
   task automatic check_pixel();
      pixel_type want, got;
      got = {rsp_tdata[7:0], rsp_tdata[15:8], rsp_tdata[23:16], rsp_tdata[24],
             rsp_tdata[29:25]};
      if (pixels_due.size() == 0) begin
         $error("unexpected response transaction %h", rsp_tdata);
         mismatch_count++;
         return;
      end
      want = pixels_due.pop_front();
      if (got.red != want.red) begin
         $error("red: expected %0d, got %0d", want.red, got.red); mismatch_count++;
      end
      if (got.green != want.green) begin
         $error("green: expected %0d, got %0d", want.green, got.green); mismatch_count++;
      end
      if (got.blue != want.blue) begin
         $error("blue: expected %0d, got %0d", want.blue, got.blue); mismatch_count++;
      end
      if (got.escaped != want.escaped) begin
         $error("escaped: expected %0d, got %0d", want.escaped, got.escaped);
         mismatch_count++;
      end
      if (got.iters != want.iters) begin
         $error("iter_count: expected %0d, got %0d", want.iters, got.iters);
         mismatch_count++;
      end
   endtask

   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) check_pixel();
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(1, 100) > recv_idle_pct);
         end
      end
   end

   // ---------------------------------------------------------------- main
   initial begin
      step_type plan [13];
      longint x, y, s;
      reset = 1'b1;
      req_tvalid = 1'b0; req_tdata = '0;
      csr_we = 1'b0; csr_idx = etc_pkg::CSR_SEED; csr_wdata = '0;
      seed_reg = '0; xoff_reg = '0; yoff_reg = '0;
      send_idle_pct = 26; recv_idle_pct = 45;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      plan = '{
         // reset values: c = 0, stays at the origin
         '{0, 0, 0, 0, 128 * ONE_Q, 128 * ONE_Q, 1, '{8'd0, 8'd0, 8'd0, 1'b0, 5'd16}},
         '{0, 0, 0, 0, COORD_LIM, COORD_LIM, 0, '0},
         '{0, 0, 0, 0, -COORD_LIM, COORD_LIM, 0, '0},
         '{0, 0, 0, 0, -COORD_LIM, -COORD_LIM, 0, '0},
         '{0, 0, 0, 0, 0, 0, 0, '0},
         // escape exactly at 2.0: d = 5, 2^32 mod 5 = 1
         '{1, 2 * ONE_Q, 0, 0, 128 * ONE_Q, 128 * ONE_Q, 1, '{8'd0, 8'd0, 8'd1, 1'b1, 5'd0}},
         '{1, -2 * ONE_Q, 0, 0, 128 * ONE_Q, 128 * ONE_Q, 1, '{8'd0, 8'd0, 8'd1, 1'b1, 5'd0}},
         // seed just under 2^16: divisor wraps to zero
         '{1, SEED_MAX, 0, 0, 128 * ONE_Q, 128 * ONE_Q, 1, '{8'd0, 8'd0, 8'd0, 1'b1, 5'd0}},
         '{1, SEED_MIN, 0, 0, 128 * ONE_Q, 128 * ONE_Q, 0, '0},
         // negative offset floors downwards, -1 -> -8 and 7 -> 0
         '{1, 0, -1, 7, 136 * ONE_Q, 128 * ONE_Q, 1, '{8'd0, 8'd0, 8'd0, 1'b0, 5'd16}},
         // c = -1 cycles between -1 and 0
         '{1, -ONE_Q, 0, 0, 128 * ONE_Q, 128 * ONE_Q, 1, '{8'd0, 8'd0, 8'd0, 1'b0, 5'd16}},
         '{1, 64'sd1288490189, -4096, 4095, COORD_LIM, -COORD_LIM, 0, '0},
         '{1, 64'sd1288490189, 4095, -4096, -4088 * ONE_Q, 4224 * ONE_Q, 0, '0}
      };
      @(posedge clock);
      foreach (plan[i]) begin
         if (plan[i].load) program_regs(plan[i].seed, plan[i].xo, plan[i].yo, 0);
         offer(plan[i].x, plan[i].y, plan[i].typed, plan[i].px);
      end

      // random phases: idling pattern changes every two phases
      for (int ph = 0; ph < PHASES; ph++) begin
         case (ph)
            0: program_regs(SEED_MIN, -4096, 4095, 0);
            1: program_regs(SEED_MAX, 4095, -4096, 0);
            default: begin
               s = ($urandom_range(0, 9) == 0) ? longint'($urandom) <<< 16
                   : longint'({32'($urandom_range(0, 4)), 32'($urandom)}) - 2 * ONE_Q;
               program_regs(s, $urandom_range(0, 8191), $urandom_range(0, 8191), ph == 2);
            end
         endcase
         send_idle_pct = (ph < 2) ? 26 : (ph < 4) ? 45 : 0;
         recv_idle_pct = (ph < 2) ? 45 : (ph < 4) ? 26 : 0;
         // long receiver hold-off: the pipeline fills and backs up the input
         if (ph == 4) stall_left = 300;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            x = ($urandom_range(0, 4) == 0) ? wide_coord() : near_coord(xoff_reg);
            y = ($urandom_range(0, 4) == 0) ? wide_coord() : near_coord(yoff_reg);
            offer(x, y, 0, '0);
         end
      end

      req_tvalid <= 1'b0;
      while (pixels_due.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (mismatch_count == 0 && pixels_due.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

[escape_time_pixel_color_unit.f]
rtl/etc_pkg.sv
rtl/etc_seed.sv
rtl/etc_iter.sv
rtl/etc_remstep.sv
rtl/etc_color.sv
rtl/escape_time_pixel_color_unit.sv
tb/sv/tb.sv
